FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock edge, off while reset is asserted
`define BPI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition in one cycle implies an expression in the next
`define BPI_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

FILE: rtl/core/bpi_pkg.sv
// package of types and constants for the bicubic pixel interpolator
`timescale 1ns / 1ps

package bpi_pkg;

	localparam int unsigned FRAC_BITS_DEFAULT = 8;
	localparam int unsigned PIX_W             = 8;
	localparam int unsigned FRAC_W            = 8;
	localparam int unsigned COL_W             = 2;
	localparam int unsigned NUM_STORED        = 3;
	localparam logic [COL_W-1:0] COL_LAST     = 2'd3;
	localparam logic [PIX_W-1:0] PIX_MAX      = 8'd255;

	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [PIX_W-1:0]  pix_m1;
		logic [PIX_W-1:0]  pix_0;
		logic [PIX_W-1:0]  pix_1;
		logic [PIX_W-1:0]  pix_2;
		logic [FRAC_W-1:0] frac_q;
		logic [FRAC_W-1:0] frac_p;
	} col_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
	} pix_item_t;

	typedef enum logic [1:0] {
		TERM_K2,
		TERM_K1,
		TERM_K0
	} term_t;

	typedef struct packed {
		logic  load_col;
		logic  load_row;
		logic  step;
		term_t term;
		logic  round;
		logic  store;
		logic  emit;
	} dp_cmd_t;

	typedef struct packed {
		logic last_col;
		logic out_busy;
	} dp_status_t;

endpackage

FILE: rtl/core/bpi_if.sv
// stream interfaces for neighbourhood columns and interpolated pixels
`timescale 1ns / 1ps

interface bpi_col_if import bpi_pkg::*; ();
	logic      valid;
	logic      ready;
	col_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bpi_pix_if import bpi_pkg::*; ();
	logic      valid;
	logic      ready;
	pix_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/bpi_controller.sv
// sequencer for the column and row cubic evaluations
`timescale 1ns / 1ps

module bpi_controller import bpi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_H2,
		S_H1,
		S_H0,
		S_RND,
		S_ROW,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   row_pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			row_pass_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_H2;
					end
				end
				S_H2: state_q <= S_H1;
				S_H1: state_q <= S_H0;
				S_H0: state_q <= S_RND;
				S_RND: begin
					if (!status.last_col) begin
						state_q <= S_IDLE;
					end else if (row_pass_q) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					row_pass_q <= 1'b1;
					state_q    <= S_H2;
				end
				S_EMIT: begin
					if (!status.out_busy) begin
						row_pass_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load_col = in_valid;
			S_H2: begin
				cmd.step = 1'b1;
				cmd.term = TERM_K2;
			end
			S_H1: begin
				cmd.step = 1'b1;
				cmd.term = TERM_K1;
			end
			S_H0: begin
				cmd.step = 1'b1;
				cmd.term = TERM_K0;
			end
			S_RND: begin
				cmd.round = 1'b1;
				cmd.store = !status.last_col;
			end
			S_ROW:  cmd.load_row = 1'b1;
			S_EMIT: cmd.emit = !status.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: rtl/core/bpi_datapath.sv
// operand registers, horner multiply-accumulate, rounding and column store
`timescale 1ns / 1ps

module bpi_datapath import bpi_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  col_item_t        item,
	input  dp_cmd_t          cmd,
	output dp_status_t       status,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] pixel_value
);

	// magnitude bound of the numerator terms, as a power of two
	localparam int unsigned E_A    = 35;
	localparam int unsigned E_B    = FRAC_BITS + 27;
	localparam int unsigned E_C    = 3 * FRAC_BITS + 9;
	localparam int unsigned E_AB   = (E_A > E_B) ? E_A : E_B;
	localparam int unsigned E_MAX  = (E_AB > E_C) ? E_AB : E_C;
	localparam int unsigned ACC_W  = E_MAX + 3;
	localparam int unsigned SH     = 3 * FRAC_BITS + 1;
	localparam int unsigned Q_W    = ACC_W - SH;
	localparam int unsigned COEF_W = 12;
	localparam int unsigned PROD_W = ACC_W + FRAC_W + 1;
	localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (3 * FRAC_BITS);

	typedef logic signed [COEF_W-1:0] coef_t;

	function automatic coef_t coef_k3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
			input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] d);
		coef_t sa, sb, sc, sd;
		sa = $signed(COEF_W'(a));
		sb = $signed(COEF_W'(b));
		sc = $signed(COEF_W'(c));
		sd = $signed(COEF_W'(d));
		return COEF_W'(-sa + 3 * sb - 3 * sc + sd);
	endfunction

	function automatic coef_t coef_k2(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
			input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] d);
		coef_t sa, sb, sc, sd;
		sa = $signed(COEF_W'(a));
		sb = $signed(COEF_W'(b));
		sc = $signed(COEF_W'(c));
		sd = $signed(COEF_W'(d));
		return COEF_W'(2 * sa - 5 * sb + 4 * sc - sd);
	endfunction

	logic [PIX_W-1:0]         opnd_q [4];
	logic [PIX_W-1:0]         opnd_next [4];
	logic [PIX_W-1:0]         res_q [NUM_STORED];
	logic [FRAC_W-1:0]        f_q;
	logic [FRAC_W-1:0]        p_q;
	logic [COL_W-1:0]         col_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [PIX_W-1:0]         v_q;
	logic                     out_valid_q;
	logic [PIX_W-1:0]         pixel_q;

	coef_t                    k_term;
	logic signed [ACC_W-1:0]  term_ext;
	logic signed [ACC_W-1:0]  term_shift;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_step;
	logic [ACC_W-1:0]         rsum;
	logic [Q_W-1:0]           quot;
	logic [PIX_W-1:0]         rounded;

	always_comb begin
		if (cmd.load_col) begin
			opnd_next[0] = item.pix_m1;
			opnd_next[1] = item.pix_0;
			opnd_next[2] = item.pix_1;
			opnd_next[3] = item.pix_2;
		end else if (cmd.load_row) begin
			opnd_next[0] = res_q[0];
			opnd_next[1] = res_q[1];
			opnd_next[2] = res_q[2];
			opnd_next[3] = v_q;
		end else begin
			opnd_next = opnd_q;
		end
	end

	// horner step: acc * f + k * S^n
	always_comb begin
		case (cmd.term)
			TERM_K2: k_term = coef_k2(opnd_q[0], opnd_q[1], opnd_q[2], opnd_q[3]);
			TERM_K1: k_term = COEF_W'($signed({1'b0, opnd_q[2]}) - $signed({1'b0, opnd_q[0]}));
			TERM_K0: k_term = $signed(COEF_W'({opnd_q[1], 1'b0}));
			default: k_term = '0;
		endcase
		term_ext = ACC_W'(k_term);
		case (cmd.term)
			TERM_K2: term_shift = term_ext <<< FRAC_BITS;
			TERM_K1: term_shift = term_ext <<< (2 * FRAC_BITS);
			TERM_K0: term_shift = term_ext <<< (3 * FRAC_BITS);
			default: term_shift = '0;
		endcase
	end

	assign prod     = acc_q * $signed({1'b0, f_q});
	assign acc_step = ACC_W'(prod) + term_shift;

	// round half away from zero; any negative quotient clamps to zero, one above PIX_MAX saturates
	assign rsum    = $unsigned(acc_q) + HALF;
	assign quot    = rsum[ACC_W-1:SH];
	assign rounded = acc_q[ACC_W-1] ? '0 :
		((|quot[Q_W-1:PIX_W]) ? PIX_MAX : quot[PIX_W-1:0]);

	always_ff @(posedge clk) begin
		opnd_q <= opnd_next;
		if (cmd.load_col) begin
			f_q   <= item.frac_q;
			p_q   <= item.frac_p;
			col_q <= item.column;
		end else if (cmd.load_row) begin
			f_q <= p_q;
		end
		if (cmd.load_col || cmd.load_row) begin
			acc_q <= ACC_W'(coef_k3(opnd_next[0], opnd_next[1], opnd_next[2], opnd_next[3]));
		end else if (cmd.step) begin
			acc_q <= acc_step;
		end
		if (cmd.round) begin
			v_q <= rounded;
		end
		if (cmd.emit) begin
			pixel_q <= v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STORED; i++) begin
				res_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				res_q[col_q] <= rounded;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.last_col = (col_q == COL_LAST);
	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign pixel_value     = pixel_q;

endmodule

FILE: rtl/core/bicubic_pixel_interpolator.sv
// Catmull-Rom bicubic pixel interpolator, one neighbourhood column per transfer.
// Columns 0 to 2 are each interpolated along y and held; column 3 is interpolated along y and
// then the four column values along x, and one pixel is presented on the result channel.
// A column transfer occupies the block for one load and three Horner steps on a single
// multiplier, then one rounding step; column 3 then adds a row load, runs the Horner steps again,
// then a second rounding step and an emit step that puts its pixel into the output register. No
// column is taken until the block is idle again. The block takes the next column while a
// finished pixel still waits on the result channel; a second pixel waits for that register to
// empty, and the input stalls meanwhile. Fractions carry FRAC_BITS fraction bits.
`timescale 1ns / 1ps

module bicubic_pixel_interpolator import bpi_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	bpi_col_if.sink   nbhd,
	bpi_pix_if.source result
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_ready;
	logic       out_valid;
	logic [PIX_W-1:0] pixel_value;

	bpi_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (nbhd.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bpi_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (nbhd.data),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (result.ready),
		.pixel_value (pixel_value)
	);

	assign nbhd.ready              = in_ready;
	assign result.valid            = out_valid;
	assign result.data.pixel_value = pixel_value;

endmodule

FILE: rtl/core/bpi_checker.sv
// port-level checks for the bicubic pixel interpolator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpi_checker import bpi_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [PIX_W-1:0] pixel_value
);

	`BPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`BPI_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(pixel_value), "result changed while stalled")
	`BPI_ASSERT_NEXT(a_busy_after_xfer, in_valid && in_ready, !in_ready, "column taken while still working")
	`BPI_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "result right after a column transfer")

endmodule

bind bicubic_pixel_interpolator bpi_checker u_bpi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (nbhd.valid),
	.in_ready    (nbhd.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.pixel_value (result.data.pixel_value)
);
